// ===== rtl/avm_pkg.sv =====
// ----------------------------------------------------------------------------
// avm_pkg: shared types and constants of the averaging voltmeter
// Field widths, scaling constants, command and result codes, and the
// divide-by-ten helper used for the BCD and ASCII digits.
// ----------------------------------------------------------------------------
package avm_pkg;

   // field widths
   localparam int unsigned ADC_W       = 10;
   localparam int unsigned TENTHS_W    = 6;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned MAX_SAMPLES = 8;
   localparam int unsigned DEF_SAMPLES = 8;

   // averaging divide: reciprocal multiply, exact for sums below 2**13
   localparam int unsigned AVG_DIV_SHIFT = 16;

   // scaling to tenths of a volt: (avg * 33 + 511) / 1023
   localparam int unsigned SCALED_W        = 16;
   localparam int unsigned SCALE_NUM       = 33;
   localparam int unsigned SCALE_ROUND     = 511;
   localparam int unsigned SCALE_RECIP_W   = 17;
   localparam int unsigned SCALE_DIV_MULT  = 65601;
   localparam int unsigned SCALE_DIV_SHIFT = 26;

   // min/max tracker reset values and highest tenths value
   localparam logic [TENTHS_W-1:0] MIN_RESET  = 6'd35;
   localparam logic [TENTHS_W-1:0] MAX_RESET  = 6'd0;
   localparam logic [TENTHS_W-1:0] TENTHS_TOP = 6'd33;

   // command codes
   localparam logic CMD_BATCH  = 1'b0;
   localparam logic CMD_SERIAL = 1'b1;

   // result kinds
   localparam logic KIND_DISPLAY = 1'b0;
   localparam logic KIND_TX      = 1'b1;

   // characters
   localparam logic [BYTE_W-1:0] REPORT_CHAR = 8'h4C;
   localparam logic [BYTE_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;

   // tag that travels with each word down the pipeline
   typedef struct packed {
      logic valid;
      logic report;
   } avm_tag_type;

   // report sequencer states
   typedef enum logic [2:0] {
      ST_FIRST = 3'b001,
      ST_SPACE = 3'b010,
      ST_MAX   = 3'b100
   } avm_rpt_state_type;

   // x / 10 for x up to 63: (x * 13) >> 7
   function automatic logic [DIGIT_W-1:0] div10(input logic [TENTHS_W-1:0] x);
      logic [9:0] prod;
      prod = {4'b0000, x} * 10'd13;
      return {1'b0, prod[9:7]};
   endfunction

   // x % 10 for x up to 63
   function automatic logic [DIGIT_W-1:0] mod10(input logic [TENTHS_W-1:0] x);
      logic [DIGIT_W-1:0] q;
      logic [TENTHS_W:0]  tens;
      logic [TENTHS_W:0]  rem;
      q    = div10(x);
      tens = {3'b000, q} * 7'd10;
      rem  = {1'b0, x} - tens;
      return rem[DIGIT_W-1:0];
   endfunction

endpackage

// ===== rtl/avm_lane.sv =====
// ----------------------------------------------------------------------------
// avm_lane: one sample lane
// Captures one ADC sample of a batch word; holds its value across serial
// words so the lane register only toggles on real conversions.
// ----------------------------------------------------------------------------
module avm_lane (
   input  logic                       clock,
   input  logic                       adv,
   input  logic                       load,
   input  logic [avm_pkg::ADC_W-1:0]  sample,
   output logic [avm_pkg::ADC_W-1:0]  sample_ff
);
   import avm_pkg::*;

   logic [ADC_W-1:0] sample_in;

   // take a new sample only for an accepted batch word
   always_comb begin
      sample_in = sample_ff;
      if (adv && load) begin
         sample_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

endmodule

// ===== rtl/avm_merge.sv =====
// ----------------------------------------------------------------------------
// avm_merge: lane merge and scaling pipeline
// Sums the lanes, divides by the lane count and scales the average to
// tenths of a volt over three registered stages.
// ----------------------------------------------------------------------------
module avm_merge #(
   parameter int unsigned SAMPLES = avm_pkg::DEF_SAMPLES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  avm_pkg::avm_tag_type                 tag,
   input  logic [SAMPLES-1:0][avm_pkg::ADC_W-1:0] lanes,
   output avm_pkg::avm_tag_type                 head,
   output logic [avm_pkg::TENTHS_W-1:0]         head_tenths
);
   import avm_pkg::*;

   localparam int unsigned SUM_W   = $clog2(SAMPLES * (2**ADC_W - 1) + 1);
   localparam int unsigned RECIP_W = AVG_DIV_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2**AVG_DIV_SHIFT + SAMPLES - 1) / SAMPLES);
   localparam int unsigned QPROD_W = SUM_W + RECIP_W;
   localparam int unsigned TPROD_W = SCALED_W + SCALE_RECIP_W;

   avm_tag_type            tag_a_ff, tag_b_ff, tag_c_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [ADC_W-1:0]       avg_ff, avg_in;
   logic [TENTHS_W-1:0]    tenths_ff, tenths_in;
   logic [QPROD_W-1:0]     qprod;
   logic [SCALED_W-1:0]    scaled;
   logic [TPROD_W-1:0]     tprod;

   // stage a: adder over the lanes
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < SAMPLES; i++) begin
         sum_in = sum_in + SUM_W'(lanes[i]);
      end
   end

   // stage b: divide by the lane count via reciprocal
   always_comb begin
      qprod  = {{RECIP_W{1'b0}}, sum_ff} * {{SUM_W{1'b0}}, RECIP};
      avg_in = qprod[AVG_DIV_SHIFT +: ADC_W];
   end

   // stage c: scale to tenths, divide by 1023 via reciprocal
   always_comb begin
      scaled    = {{(SCALED_W-ADC_W){1'b0}}, avg_ff} * SCALED_W'(SCALE_NUM)
                  + SCALED_W'(SCALE_ROUND);
      tprod     = {{SCALE_RECIP_W{1'b0}}, scaled}
                  * {{SCALED_W{1'b0}}, SCALE_RECIP_W'(SCALE_DIV_MULT)};
      tenths_in = tprod[SCALE_DIV_SHIFT +: TENTHS_W];
   end

   // data registers
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff    <= sum_in;
         avg_ff    <= avg_in;
         tenths_ff <= tenths_in;
      end
   end

   // tag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else if (adv) begin
         tag_a_ff <= tag;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   assign head        = tag_c_ff;
   assign head_tenths = tenths_ff;

endmodule

// ===== rtl/avm_out.sv =====
// ----------------------------------------------------------------------------
// avm_out: min/max tracker and result register
// Turns the pipeline head into display words or a three-word min/max
// report, and holds each result word until the receiver takes it.
// ----------------------------------------------------------------------------
module avm_out (
   input  logic                          clock,
   input  logic                          reset,
   input  avm_pkg::avm_tag_type          head,
   input  logic [avm_pkg::TENTHS_W-1:0]  head_tenths,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [avm_pkg::BYTE_W-1:0]    rsp_display_code,
   output logic [avm_pkg::TENTHS_W-1:0]  rsp_tenths,
   output logic [avm_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                          rsp_last
);
   import avm_pkg::*;

   avm_rpt_state_type    state_ff, state_in;
   logic [TENTHS_W-1:0]  min_ff, min_in;
   logic [TENTHS_W-1:0]  max_ff, max_in;
   logic                 valid_ff, valid_in;
   logic                 kind_ff, kind_in;
   logic [BYTE_W-1:0]    code_ff, code_in;
   logic [TENTHS_W-1:0]  tenths_ff, tenths_in;
   logic [BYTE_W-1:0]    tx_ff, tx_in;
   logic                 last_ff, last_in;
   logic                 load;

   // output register free or being emptied this cycle
   assign load = head.valid && (!valid_ff || !rsp_stall);
   assign pop  = load && (!head.report || state_ff == ST_MAX);

   // report sequencer and result word
   always_comb begin
      state_in  = state_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      valid_in  = valid_ff && rsp_stall;
      kind_in   = kind_ff;
      code_in   = code_ff;
      tenths_in = tenths_ff;
      tx_in     = tx_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = 1'b1;
         if (!head.report) begin
            kind_in   = KIND_DISPLAY;
            code_in   = {div10(head_tenths), mod10(head_tenths)};
            tenths_in = head_tenths;
            tx_in     = '0;
            last_in   = 1'b1;
            if (head_tenths < min_ff) begin
               min_in = head_tenths;
            end
            if (head_tenths > max_ff) begin
               max_in = head_tenths;
            end
         end else begin
            kind_in   = KIND_TX;
            code_in   = '0;
            tenths_in = '0;
            unique case (state_ff)
               ST_FIRST: begin
                  tx_in    = ASCII_ZERO + BYTE_W'(div10(min_ff));
                  last_in  = 1'b0;
                  state_in = ST_SPACE;
               end
               ST_SPACE: begin
                  tx_in    = ASCII_SPACE;
                  last_in  = 1'b0;
                  state_in = ST_MAX;
               end
               ST_MAX: begin
                  tx_in    = ASCII_ZERO + BYTE_W'(div10(max_ff));
                  last_in  = 1'b1;
                  state_in = ST_FIRST;
               end
               default: begin
                  tx_in    = '0;
                  last_in  = 1'b0;
                  state_in = ST_FIRST;
               end
            endcase
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FIRST;
         min_ff   <= MIN_RESET;
         max_ff   <= MAX_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      code_ff   <= code_in;
      tenths_ff <= tenths_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_display_code = code_ff;
   assign rsp_tenths       = tenths_ff;
   assign rsp_tx_byte      = tx_ff;
   assign rsp_last         = last_ff;

`ifndef NO_ASSERTIONS
   // mid-report the output register always holds a word
   a_report_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FIRST) |-> valid_ff)
      else $error("report in progress with empty output register");

   // tracker stays within range: min up to its reset value, max up to the top tenths value
   a_minmax_range: assert property (@(posedge clock) disable iff (reset)
      (min_ff <= MIN_RESET) && (max_ff <= TENTHS_TOP))
      else $error("min/max tracker out of range");

   // a report word leaves the head only as its third word is loaded
   a_pop_report: assert property (@(posedge clock) disable iff (reset)
      (pop && head.report) |-> (state_ff == ST_MAX))
      else $error("report popped before its last word");

   // display words are always the last of their item
   a_display_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_DISPLAY) |-> last_ff)
      else $error("display word without last");

   // sequencer state stays one-hot
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("report sequencer state not one-hot");
`endif

endmodule

// ===== rtl/averaging_voltmeter_min_max.sv =====
// ----------------------------------------------------------------------------
// averaging_voltmeter_min_max: averaging voltmeter with min/max report
// Lanes capture a batch of ADC samples, a merge pipeline averages and
// scales them to tenths of a volt, and an output stage tracks min/max.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per handshake (req_valid high, req_stall low).
//   req_command 0 carries a sample batch in req_sample_0.., of which the
//   first SAMPLES are averaged; req_command 1 carries req_rx_byte, where
//   'L' asks for a min/max report and any other byte is dropped.
//   rsp channel: a batch gives one display word (BCD volts and tenths);
//   'L' gives three transmit words: min tens digit, space, max tens digit,
//   the last with rsp_last set. Min/max cover all batches taken before.
//   The lane register loads at the accepting edge; the word then passes
//   the sum, average and scale registers and the output register.
//   Throughput: one word per cycle when nothing holds the pipeline; a report
//   holds it while its three words go out of the single output register.
//   A stall on rsp holds the output register and the whole pipeline;
//   req_stall rises once the pipeline head cannot move.
//   Reset (synchronous): pipeline empty, min = 35, max = 0.
// ----------------------------------------------------------------------------
module averaging_voltmeter_min_max #(
   parameter int unsigned SAMPLES = avm_pkg::DEF_SAMPLES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_0,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_1,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_2,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_3,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_4,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_5,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_6,
   input  logic [avm_pkg::ADC_W-1:0]     req_sample_7,
   input  logic [avm_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic [avm_pkg::BYTE_W-1:0]    rsp_display_code,
   output logic [avm_pkg::TENTHS_W-1:0]  rsp_tenths,
   output logic [avm_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                          rsp_last
);
   import avm_pkg::*;

   logic [MAX_SAMPLES-1:0][ADC_W-1:0]  req_samples;
   logic [SAMPLES-1:0][ADC_W-1:0]      lane_q;
   avm_tag_type                        tag_ff, tag_in;
   avm_tag_type                        head;
   logic [TENTHS_W-1:0]                head_tenths;
   logic                               pop;
   logic                               adv;
   logic                               accept;
   logic                               batch;

   assign req_samples = {req_sample_7, req_sample_6, req_sample_5, req_sample_4,
                         req_sample_3, req_sample_2, req_sample_1, req_sample_0};

   // pipeline moves when its head is empty or leaving
   assign adv       = !head.valid || pop;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign batch     = req_command == CMD_BATCH;

   // lane-stage tag: drop serial bytes other than the report request
   always_comb begin
      tag_in.valid  = accept && (batch || req_rx_byte == REPORT_CHAR);
      tag_in.report = !batch;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (adv) begin
         tag_ff <= tag_in;
      end
   end

   // sample lanes
   for (genvar i = 0; i < SAMPLES; i++) begin : g_lane
      avm_lane u_lane (
         .clock     (clock),
         .adv       (adv),
         .load      (accept && batch),
         .sample    (req_samples[i]),
         .sample_ff (lane_q[i])
      );
   end

   // merge and scaling pipeline
   avm_merge #(
      .SAMPLES (SAMPLES)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .tag         (tag_ff),
      .lanes       (lane_q),
      .head        (head),
      .head_tenths (head_tenths)
   );

   // min/max tracking and result register
   avm_out u_out (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_tenths      (head_tenths),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_display_code (rsp_display_code),
      .rsp_tenths       (rsp_tenths),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== sim/avm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avm_checker: scoreboard for the averaging voltmeter
// Watches the req and rsp channels, predicts the display and transmit
// words of every accepted request from its own min/max copy, and compares
// each accepted rsp word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module avm_checker #(
   parameter int unsigned SAMPLES = avm_pkg::DEF_SAMPLES
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                req_valid,
   input  logic                                                req_stall,
   input  logic                                                req_command,
   input  logic [avm_pkg::MAX_SAMPLES-1:0][avm_pkg::ADC_W-1:0] req_sample,
   input  logic [avm_pkg::BYTE_W-1:0]                          req_rx_byte,
   input  logic                                                rsp_valid,
   input  logic                                                rsp_stall,
   input  logic                                                rsp_kind,
   input  logic [avm_pkg::BYTE_W-1:0]                          rsp_display_code,
   input  logic [avm_pkg::TENTHS_W-1:0]                        rsp_tenths,
   input  logic [avm_pkg::BYTE_W-1:0]                          rsp_tx_byte,
   input  logic                                                rsp_last,
   output int unsigned                                         mismatch_count,
   output int unsigned                                         words_outstanding
);
   import avm_pkg::*;

   localparam int unsigned FULL_SCALE = 1023;
   localparam int unsigned LANES_USED = (SAMPLES < 1) ? 1 :
                                        ((SAMPLES > MAX_SAMPLES) ? MAX_SAMPLES : SAMPLES);

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   display_code;
      logic [TENTHS_W-1:0] tenths;
      logic [BYTE_W-1:0]   tx_byte;
      logic                last;
   } avm_word_type;

   avm_word_type        expected_words[$];
   logic [TENTHS_W-1:0] min_tenths = MIN_RESET;
   logic [TENTHS_W-1:0] max_tenths = MAX_RESET;
   int unsigned         errors_seen = 0;

   function automatic avm_word_type make_word(input logic kind,
                                              input logic [BYTE_W-1:0] code,
                                              input logic [TENTHS_W-1:0] tenths,
                                              input logic [BYTE_W-1:0] tx_byte,
                                              input logic last);
      avm_word_type w;
      w.kind         = kind;
      w.display_code = code;
      w.tenths       = tenths;
      w.tx_byte      = tx_byte;
      w.last         = last;
      return w;
   endfunction

   // expected words of one request, min/max updated along the way
   task automatic predict_reading(input logic command,
                                  input logic [MAX_SAMPLES-1:0][ADC_W-1:0] samples,
                                  input logic [BYTE_W-1:0] rx_byte);
      int unsigned         sum;
      int unsigned         avg;
      int unsigned         scaled;
      logic [TENTHS_W-1:0] volts_tenths;
      logic [3:0]          whole_digit;
      logic [3:0]          tenth_digit;
      logic [BYTE_W-1:0]   min_char;
      logic [BYTE_W-1:0]   max_char;
      if (command == CMD_BATCH) begin
         sum = 0;
         for (int i = 0; i < LANES_USED; i++) sum += samples[i];
         avg          = sum / LANES_USED;
         scaled       = (avg * SCALE_NUM + SCALE_ROUND) / FULL_SCALE;
         volts_tenths = scaled[TENTHS_W-1:0];
         whole_digit  = 4'(scaled / 10);
         tenth_digit  = 4'(scaled % 10);
         if (volts_tenths < min_tenths) min_tenths = volts_tenths;
         if (volts_tenths > max_tenths) max_tenths = volts_tenths;
         expected_words.push_back(make_word(KIND_DISPLAY, {whole_digit, tenth_digit},
                                            volts_tenths, '0, 1'b1));
      end else if (rx_byte == REPORT_CHAR) begin
         min_char = ASCII_ZERO + BYTE_W'(min_tenths / 10);
         max_char = ASCII_ZERO + BYTE_W'(max_tenths / 10);
         expected_words.push_back(make_word(KIND_TX, '0, '0, min_char, 1'b0));
         expected_words.push_back(make_word(KIND_TX, '0, '0, ASCII_SPACE, 1'b0));
         expected_words.push_back(make_word(KIND_TX, '0, '0, max_char, 1'b1));
      end
   endtask

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $display("%0t ns: rsp_%s mismatch, expected 0x%0h, got 0x%0h",
                  $time, name, want, got);
         errors_seen++;
      end
   endfunction

   // rsp words are checked before the request of the same edge is predicted
   always @(posedge clock) begin : watch
      avm_word_type want;
      if (reset) begin
         expected_words.delete();
         min_tenths = MIN_RESET;
         max_tenths = MAX_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display({"%0t ns: unexpected rsp word, expected none, ",
                         "got kind %0d code 0x%h tenths %0d tx 0x%h last %0d"},
                        $time, rsp_kind, rsp_display_code, rsp_tenths, rsp_tx_byte,
                        rsp_last);
               errors_seen++;
            end else begin
               want = expected_words.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_kind));
               compare_field("display_code", 32'(want.display_code),
                             32'(rsp_display_code));
               compare_field("tenths", 32'(want.tenths), 32'(rsp_tenths));
               compare_field("tx_byte", 32'(want.tx_byte), 32'(rsp_tx_byte));
               compare_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall) predict_reading(req_command, req_sample, req_rx_byte);
      end
      mismatch_count    <= errors_seen;
      words_outstanding <= expected_words.size();
   end

endmodule

// ===== sim/tb_averaging_voltmeter_min_max.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_averaging_voltmeter_min_max: regression for the averaging voltmeter
// Drives directed and random sample batches and serial bytes with random
// gaps and back-pressure, one long rsp hold-off and two full drains, and
// reports the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_averaging_voltmeter_min_max;
   import avm_pkg::*;

   localparam int unsigned WORD_TARGET = 220;
   localparam int unsigned HOLD_CYCLES = 64;
   localparam int unsigned TAIL_CYCLES = 16;
   localparam int unsigned TIMEOUT_NS  = 1_000_000;

   typedef logic [MAX_SAMPLES-1:0][ADC_W-1:0] sample_set_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_command      = CMD_BATCH;
   sample_set_type      req_sample       = '0;
   logic [BYTE_W-1:0]   req_rx_byte      = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic                rsp_kind;
   logic [BYTE_W-1:0]   rsp_display_code;
   logic [TENTHS_W-1:0] rsp_tenths;
   logic [BYTE_W-1:0]   rsp_tx_byte;
   logic                rsp_last;
   int unsigned         mismatch_count;
   int unsigned         words_outstanding;

   bit calm_stretch = 1'b0;
   bit hold_request = 1'b0;

   averaging_voltmeter_min_max DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_0     (req_sample[0]),
      .req_sample_1     (req_sample[1]),
      .req_sample_2     (req_sample[2]),
      .req_sample_3     (req_sample[3]),
      .req_sample_4     (req_sample[4]),
      .req_sample_5     (req_sample[5]),
      .req_sample_6     (req_sample[6]),
      .req_sample_7     (req_sample[7]),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_display_code (rsp_display_code),
      .rsp_tenths       (rsp_tenths),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last)
   );

   avm_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_sample        (req_sample),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_display_code  (rsp_display_code),
      .rsp_tenths        (rsp_tenths),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last          (rsp_last),
      .mismatch_count    (mismatch_count),
      .words_outstanding (words_outstanding)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #(TIMEOUT_NS);
      $display("averaging_voltmeter_min_max regression: fail");
      $finish;
   end

   // receiver: random back-pressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm_stretch && ($urandom_range(99) < 30);
      end
   end

   // offer one word, wait for acceptance, then maybe leave a gap
   task automatic offer_word(input logic command, input sample_set_type samples,
                             input logic [BYTE_W-1:0] rx_byte);
      req_valid   <= 1'b1;
      req_command <= command;
      req_sample  <= samples;
      req_rx_byte <= rx_byte;
      do @(posedge clock); while (req_stall);
      if (!calm_stretch && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   function automatic sample_set_type noise_samples();
      sample_set_type s;
      for (int i = 0; i < MAX_SAMPLES; i++) s[i] = ADC_W'($urandom);
      return s;
   endfunction

   function automatic sample_set_type uniform_samples(input logic [ADC_W-1:0] level);
      sample_set_type s;
      for (int i = 0; i < MAX_SAMPLES; i++) s[i] = level;
      return s;
   endfunction

   // batch shapes: free random, flat level, rail to rail, low end
   function automatic sample_set_type random_batch();
      sample_set_type s;
      int unsigned    shape;
      shape = $urandom_range(3);
      s = noise_samples();
      case (shape)
         1: s = uniform_samples(ADC_W'($urandom));
         2: for (int i = 0; i < MAX_SAMPLES; i++) s[i] = $urandom_range(1) ? '1 : '0;
         3: for (int i = 0; i < MAX_SAMPLES; i++) s[i] = ADC_W'($urandom_range(0, 40));
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic [BYTE_W-1:0] other_byte();
      logic [BYTE_W-1:0] b;
      do b = BYTE_W'($urandom); while (b == REPORT_CHAR);
      return b;
   endfunction

   task automatic send_batch(input sample_set_type samples);
      offer_word(CMD_BATCH, samples, BYTE_W'($urandom));
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] rx_byte);
      offer_word(CMD_SERIAL, noise_samples(), rx_byte);
   endtask

   // sender pause until every predicted word is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (words_outstanding != 0);
   endtask

   // every word sent counts, ignored bytes included
   task automatic random_phase(input int unsigned count);
      int unsigned done_items;
      int unsigned pick;
      done_items = 0;
      while (done_items < count) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_batch(random_batch());
         end else if (pick < 80) begin
            send_byte(REPORT_CHAR);
         end else begin
            send_byte(other_byte());
         end
         done_items++;
      end
   endtask

   // stimulus and verdict
   initial begin
      sample_set_type lone;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // report straight out of reset, then bytes that must be dropped
      send_byte(REPORT_CHAR);
      send_byte(8'h6C);
      send_byte(8'h00);
      send_byte(8'hFF);
      offer_word(CMD_SERIAL, '1, other_byte());

      // rails and a report of the new min/max
      send_batch('0);
      send_batch('1);
      send_byte(REPORT_CHAR);

      // rounding edges at the bottom and top of the scale
      send_batch(uniform_samples(10'd15));
      send_batch(uniform_samples(10'd16));
      send_batch(uniform_samples(10'd1007));
      send_batch(uniform_samples(10'd1008));
      send_batch(uniform_samples(10'd512));

      // truncating average: sums that do not divide evenly
      lone = '0;
      lone[0] = 10'd7;
      send_batch(lone);
      lone = '0;
      lone[MAX_SAMPLES-1] = '1;
      send_batch(lone);

      // report char carried by a batch is ignored
      offer_word(CMD_BATCH, noise_samples(), REPORT_CHAR);
      send_byte(REPORT_CHAR);

      random_phase(70);

      // long rsp hold-off while the sender keeps pushing
      calm_stretch = 1'b1;
      hold_request = 1'b1;
      random_phase(40);
      calm_stretch = 1'b0;
      wait_drained();

      // stretch without any idling on either side
      calm_stretch = 1'b1;
      random_phase(40);
      calm_stretch = 1'b0;

      random_phase(WORD_TARGET - 150);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && words_outstanding == 0) begin
         $display("averaging_voltmeter_min_max regression: pass");
      end else begin
         $display("averaging_voltmeter_min_max regression: fail");
      end
      $finish;
   end

endmodule
